>>> rtl/jmsp_pkg.sv
// ----------------------------------------------------------------------------
// jmsp_pkg
// Types, codes and helper functions shared by the JPEG marker segment parser.
// ----------------------------------------------------------------------------
package jmsp_pkg;

   // Result kinds
   localparam logic [1:0] KIND_COMMENT = 2'd0;
   localparam logic [1:0] KIND_FRAME   = 2'd1;
   localparam logic [1:0] KIND_DONE    = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   // Error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_BAD_START = 3'd1;
   localparam logic [2:0] ERR_FILL      = 3'd2;
   localparam logic [2:0] ERR_LENGTH    = 3'd3;
   localparam logic [2:0] ERR_TRUNCATED = 3'd4;
   localparam logic [2:0] ERR_EOI       = 3'd5;

   // Marker and byte constants
   localparam logic [7:0] BYTE_FILL   = 8'hFF;
   localparam logic [7:0] MARKER_SOI  = 8'hD8;
   localparam logic [7:0] MARKER_SOS  = 8'hDA;
   localparam logic [7:0] MARKER_EOI  = 8'hD9;
   localparam logic [7:0] MARKER_COM  = 8'hFE;
   localparam logic [7:0] MARKER_APP0 = 8'hE0;
   localparam logic [7:0] MARKER_APP1 = 8'hE1;
   localparam logic [7:0] SOF_FIRST   = 8'hC0;
   localparam logic [7:0] SOF_LAST    = 8'hCF;

   localparam int unsigned MAXFILL   = 6;
   localparam int unsigned SECTION_W = 6;

   // Parse phases, one-hot
   typedef enum logic [7:0] {
      PH_SOI0 = 8'b0000_0001,
      PH_SOI1 = 8'b0000_0010,
      PH_FILL = 8'b0000_0100,
      PH_LENH = 8'b0000_1000,
      PH_LENL = 8'b0001_0000,
      PH_BODY = 8'b0010_0000,
      PH_PEND = 8'b0100_0000,
      PH_IDLE = 8'b1000_0000
   } phase_type;

   // Parser state; the payload position saturates at 7 (only 0..5 matter)
   typedef struct packed {
      phase_type              phase;
      logic [2:0]             fill_count;
      logic [7:0]             current_marker;
      logic [7:0]             length_high;
      logic [15:0]            bytes_left;
      logic [2:0]             segment_index;
      logic [15:0]            height;
      logic [15:0]            width;
      logic                   color;
      logic                   exif_match;
      logic [SECTION_W-1:0]   section_count;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:          PH_SOI0,
      fill_count:     3'd0,
      current_marker: 8'd0,
      length_high:    8'd0,
      bytes_left:     16'd0,
      segment_index:  3'd0,
      height:         16'd0,
      width:          16'd0,
      color:          1'b0,
      exif_match:     1'b1,
      section_count:  '0
   };

   // One result item
   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [7:0]  comment_byte;
      logic [15:0] frame_height;
      logic [15:0] frame_width;
      logic        is_color;
      logic [7:0]  process_marker;
      logic [2:0]  error_code;
   } result_type;

   // Start-of-frame markers: C0..CF except DHT, JPG and DAC
   function automatic logic is_sof(input logic [7:0] m);
      logic in_range;
      logic excluded;
      in_range = m inside {[SOF_FIRST:SOF_LAST]};
      excluded = m inside {8'hC4, 8'hC8, 8'hCC};
      return in_range && !excluded;
   endfunction

   // "Exif" tag characters by position
   function automatic logic [7:0] exif_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0:    c = 8'h45;
         2'd1:    c = 8'h78;
         2'd2:    c = 8'h69;
         default: c = 8'h66;
      endcase
      return c;
   endfunction

endpackage

>>> rtl/jpeg_marker_segment_parser.sv
// ----------------------------------------------------------------------------
// jpeg_marker_segment_parser
// Walks the marker segments of a JPEG byte stream and reports comments,
// frame size and completion or errors.
// ----------------------------------------------------------------------------
// Usage:
//   req_*: one file byte per request, with first/last file markers.
//   rsp_*: at most one result per request (comment byte, frame info, done
//   or error). Most requests give no result.
//   A request is taken when req_valid is high and req_stall is low. The
//   result of a request is in the output register the cycle after it is
//   taken. One request per cycle, sustained; the only limit is the
//   single output register, which is freed in the cycle it is read.
//   req_stall is raised only while a result sits in the output register
//   and rsp_stall holds it there.
//   Reset (synchronous, active high) returns the parser to expecting the
//   first start byte and empties the output register. A request with
//   req_first_byte set restarts the parser at any time.
//   After done or an error, bytes are swallowed without results until the
//   next first byte.
// ----------------------------------------------------------------------------
module jpeg_marker_segment_parser #(
   parameter int unsigned MAX_SEGMENTS = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_comment_byte,
   output logic [15:0] rsp_frame_height,
   output logic [15:0] rsp_frame_width,
   output logic        rsp_is_color,
   output logic [7:0]  rsp_process_marker,
   output logic [2:0]  rsp_error_code
);

   localparam logic [jmsp_pkg::SECTION_W-1:0] SEG_LIMIT =
      jmsp_pkg::SECTION_W'(MAX_SEGMENTS - 1);

   jmsp_pkg::state_type  state_ff, state_in;
   jmsp_pkg::result_type step_res;
   jmsp_pkg::result_type out_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 req_accept;

   // output slot is busy only while a result waits on a stalled receiver
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   jmsp_step u_step (
      .cur        (state_ff),
      .data_byte  (req_data_byte),
      .first_byte (req_first_byte),
      .last_byte  (req_last_byte),
      .seg_limit  (SEG_LIMIT),
      .nxt        (state_in),
      .res        (step_res)
   );

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jmsp_pkg::STATE_RESET;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (req_accept && step_res.valid) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && step_res.valid) begin
         out_ff <= step_res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = out_ff.kind;
   assign rsp_comment_byte   = out_ff.comment_byte;
   assign rsp_frame_height   = out_ff.frame_height;
   assign rsp_frame_width    = out_ff.frame_width;
   assign rsp_is_color       = out_ff.is_color;
   assign rsp_process_marker = out_ff.process_marker;
   assign rsp_error_code     = out_ff.error_code;

`ifndef SYNTHESIS
   // a pending done always comes out on the next request
   a_pend_done: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_first_byte && state_ff.phase == jmsp_pkg::PH_PEND
      |=> rsp_valid && rsp_kind == jmsp_pkg::KIND_DONE)
      else $error("pending done not delivered");

   // a stopped parser stays stopped and silent until a new file
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_first_byte && state_ff.phase == jmsp_pkg::PH_IDLE
      |=> !rsp_valid && state_ff.phase == jmsp_pkg::PH_IDLE)
      else $error("result after done or error");

   // frame fields are zero on every non-frame result
   a_frame_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != jmsp_pkg::KIND_FRAME
      |-> rsp_frame_height == 16'd0 && rsp_frame_width == 16'd0 &&
          !rsp_is_color && rsp_process_marker == 8'd0)
      else $error("frame fields set on non-frame result");

   // input is held back only by a full, stalled output register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with free output");
`endif

endmodule

>>> rtl/jmsp_step.sv
// ----------------------------------------------------------------------------
// jmsp_step
// Next-state and result logic for one byte of the marker segment parser.
// ----------------------------------------------------------------------------
module jmsp_step (
   input  jmsp_pkg::state_type              cur,
   input  logic [7:0]                       data_byte,
   input  logic                             first_byte,
   input  logic                             last_byte,
   input  logic [jmsp_pkg::SECTION_W-1:0]   seg_limit,
   output jmsp_pkg::state_type              nxt,
   output jmsp_pkg::result_type             res
);

   jmsp_pkg::state_type s;
   logic        hit;
   logic [1:0]  kind;
   logic [2:0]  err;
   logic [7:0]  cbyte;
   logic        done_due;
   logic        do_finish;
   logic        counted;
   logic [15:0] len;
   logic [15:0] left_dec;
   logic        sof;

   always_comb begin
      s         = first_byte ? jmsp_pkg::STATE_RESET : cur;
      nxt       = s;
      hit       = 1'b0;
      kind      = jmsp_pkg::KIND_COMMENT;
      err       = jmsp_pkg::ERR_NONE;
      cbyte     = 8'd0;
      done_due  = 1'b0;
      do_finish = 1'b0;
      counted   = 1'b1;
      len       = {s.length_high, data_byte};
      left_dec  = s.bytes_left - 16'd1;
      sof       = jmsp_pkg::is_sof(s.current_marker);

      // per-phase byte handling
      case (s.phase)
         jmsp_pkg::PH_SOI0: begin
            if (data_byte != jmsp_pkg::BYTE_FILL) begin
               hit = 1'b1; kind = jmsp_pkg::KIND_ERROR; err = jmsp_pkg::ERR_BAD_START;
               nxt.phase = jmsp_pkg::PH_IDLE;
            end else begin
               nxt.phase = jmsp_pkg::PH_SOI1;
            end
         end
         jmsp_pkg::PH_SOI1: begin
            if (data_byte != jmsp_pkg::MARKER_SOI) begin
               hit = 1'b1; kind = jmsp_pkg::KIND_ERROR; err = jmsp_pkg::ERR_BAD_START;
               nxt.phase = jmsp_pkg::PH_IDLE;
            end else begin
               nxt.phase      = jmsp_pkg::PH_FILL;
               nxt.fill_count = 3'd0;
            end
         end
         jmsp_pkg::PH_FILL: begin
            if (data_byte == jmsp_pkg::BYTE_FILL) begin
               if (s.fill_count >= 3'(jmsp_pkg::MAXFILL)) begin
                  hit = 1'b1; kind = jmsp_pkg::KIND_ERROR; err = jmsp_pkg::ERR_FILL;
                  nxt.phase = jmsp_pkg::PH_IDLE;
               end else begin
                  nxt.fill_count = s.fill_count + 3'd1;
               end
            end else begin
               nxt.current_marker = data_byte;
               nxt.fill_count     = 3'd0;
               if (data_byte == jmsp_pkg::MARKER_EOI) begin
                  hit = 1'b1; kind = jmsp_pkg::KIND_ERROR; err = jmsp_pkg::ERR_EOI;
                  nxt.phase = jmsp_pkg::PH_IDLE;
               end else begin
                  nxt.phase = jmsp_pkg::PH_LENH;
               end
            end
         end
         jmsp_pkg::PH_LENH: begin
            nxt.length_high = data_byte;
            nxt.phase       = jmsp_pkg::PH_LENL;
         end
         jmsp_pkg::PH_LENL: begin
            if (len[15:1] == 15'd0) begin
               hit = 1'b1; kind = jmsp_pkg::KIND_ERROR; err = jmsp_pkg::ERR_LENGTH;
               nxt.phase = jmsp_pkg::PH_IDLE;
            end else begin
               nxt.bytes_left    = len - 16'd2;
               nxt.segment_index = 3'd0;
               nxt.height        = 16'd0;
               nxt.width         = 16'd0;
               nxt.color         = 1'b0;
               nxt.exif_match    = 1'b1;
               nxt.phase         = jmsp_pkg::PH_BODY;
               do_finish         = (len == 16'd2);
            end
         end
         jmsp_pkg::PH_BODY: begin
            // comment bytes go out, zero bytes dropped
            if (s.current_marker == jmsp_pkg::MARKER_COM && data_byte != 8'd0) begin
               hit = 1'b1; kind = jmsp_pkg::KIND_COMMENT; cbyte = data_byte;
            end
            // frame header capture
            if (sof) begin
               case (s.segment_index)
                  3'd1:    nxt.height[15:8] = data_byte;
                  3'd2:    nxt.height[7:0]  = data_byte;
                  3'd3:    nxt.width[15:8]  = data_byte;
                  3'd4:    nxt.width[7:0]   = data_byte;
                  3'd5:    nxt.color        = (data_byte == 8'd3);
                  default: ;
               endcase
            end
            // "Exif" tag check on the first four payload bytes
            if (s.current_marker == jmsp_pkg::MARKER_APP1 && !s.segment_index[2] &&
                data_byte != jmsp_pkg::exif_char(s.segment_index[1:0])) begin
               nxt.exif_match = 1'b0;
            end
            if (s.segment_index != 3'd7) begin
               nxt.segment_index = s.segment_index + 3'd1;
            end
            nxt.bytes_left = left_dec;
            do_finish      = (left_dec == 16'd0);
         end
         jmsp_pkg::PH_PEND: begin
            hit = 1'b1; kind = jmsp_pkg::KIND_DONE;
            nxt.phase = jmsp_pkg::PH_IDLE;
         end
         default: ;
      endcase

      // end of segment: counting, frame report, done check
      if (do_finish) begin
         nxt.phase      = jmsp_pkg::PH_FILL;
         nxt.fill_count = 3'd0;
         if (s.current_marker == jmsp_pkg::MARKER_SOS) begin
            nxt.section_count = s.section_count + jmsp_pkg::SECTION_W'(1);
            done_due          = 1'b1;
         end else begin
            if (s.current_marker == jmsp_pkg::MARKER_APP0) begin
               counted = 1'b0;
            end
            if (s.current_marker == jmsp_pkg::MARKER_APP1 &&
                !(nxt.exif_match && nxt.segment_index >= 3'd4)) begin
               counted = 1'b0;
            end
            if (counted) begin
               nxt.section_count = s.section_count + jmsp_pkg::SECTION_W'(1);
            end
            if (sof) begin
               hit = 1'b1; kind = jmsp_pkg::KIND_FRAME;
            end
            if (nxt.section_count >= seg_limit) begin
               done_due = 1'b1;
            end
         end
      end

      // done either now or on the next byte when a data result is out
      if (done_due) begin
         if (hit && !last_byte) begin
            nxt.phase = jmsp_pkg::PH_PEND;
         end else begin
            hit = 1'b1; kind = jmsp_pkg::KIND_DONE;
            nxt.phase = jmsp_pkg::PH_IDLE;
         end
      end

      // file ends while still parsing
      if (last_byte && nxt.phase != jmsp_pkg::PH_IDLE &&
          !(hit && (kind == jmsp_pkg::KIND_DONE || kind == jmsp_pkg::KIND_ERROR))) begin
         hit = 1'b1; kind = jmsp_pkg::KIND_ERROR; err = jmsp_pkg::ERR_TRUNCATED;
         nxt.phase = jmsp_pkg::PH_IDLE;
      end

      // after done or error nothing happens until a new file starts
      if (s.phase == jmsp_pkg::PH_IDLE) begin
         nxt = s;
         hit = 1'b0;
      end

      res.valid          = hit;
      res.kind           = kind;
      res.comment_byte   = (kind == jmsp_pkg::KIND_COMMENT) ? cbyte : 8'd0;
      res.frame_height   = (kind == jmsp_pkg::KIND_FRAME) ? nxt.height : 16'd0;
      res.frame_width    = (kind == jmsp_pkg::KIND_FRAME) ? nxt.width : 16'd0;
      res.is_color       = (kind == jmsp_pkg::KIND_FRAME) && nxt.color;
      res.process_marker = (kind == jmsp_pkg::KIND_FRAME) ? nxt.current_marker : 8'd0;
      res.error_code     = (kind == jmsp_pkg::KIND_ERROR) ? err : jmsp_pkg::ERR_NONE;
   end

endmodule

>>> tb/jpeg_marker_segment_parser_test.sv
// ----------------------------------------------------------------------------
// jpeg_marker_segment_parser_test
// Self-checking bench for the JPEG marker segment parser. A short table of
// directed requests is followed by randomly built files. Most of these files
// are well formed, and the rest are broken or plain noise. Every accepted
// request goes through a behavioral parser that predicts its result. Each
// result is checked against the oldest prediction. Both sides of the block
// idle at random.
// ----------------------------------------------------------------------------
module jpeg_marker_segment_parser_test;
   timeunit 1ns;
   timeprecision 1ps;
   import jmsp_pkg::*;

   localparam int unsigned MAX_SEGMENTS = 20;
   localparam int          ITEM_TARGET  = 1200;
   localparam int          IDLE_PCT     = 37;
   localparam int          CALM_FIRST   = 500;
   localparam int          CALM_LAST    = 800;
   localparam int          DIR_ROWS     = 29;

   // Markers that sit in the SOFn range but are not frame headers, plus DQT and the Exif tag
   localparam logic [7:0]  MARKER_DHT = 8'hC4;
   localparam logic [7:0]  MARKER_JPG = 8'hC8;
   localparam logic [7:0]  MARKER_DAC = 8'hCC;
   localparam logic [7:0]  MARKER_DQT = 8'hDB;
   localparam logic [31:0] EXIF_TAG   = 32'h4578_6966;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  comment_byte;
      logic [15:0] frame_height;
      logic [15:0] frame_width;
      logic        is_color;
      logic [7:0]  process_marker;
      logic [2:0]  error_code;
   } parse_result_t;

   typedef struct packed {
      logic [7:0] data;
      logic       first;
      logic       last;
   } file_byte_t;

   typedef struct packed {
      logic [7:0]    data;
      logic          first;
      logic          last;
      logic          typed;
      parse_result_t want;
   } dir_row_t;

   localparam parse_result_t NO_RES    = '0;
   localparam parse_result_t R_TRUNC   = '{KIND_ERROR, 8'h00, 16'h0, 16'h0, 1'b0, 8'h00,
                                           ERR_TRUNCATED};
   localparam parse_result_t R_BAD_SOI = '{KIND_ERROR, 8'h00, 16'h0, 16'h0, 1'b0, 8'h00,
                                           ERR_BAD_START};
   localparam parse_result_t R_EOI     = '{KIND_ERROR, 8'h00, 16'h0, 16'h0, 1'b0, 8'h00,
                                           ERR_EOI};
   localparam parse_result_t R_COM_FF  = '{KIND_COMMENT, 8'hFF, 16'h0, 16'h0, 1'b0, 8'h00,
                                           ERR_NONE};
   localparam parse_result_t R_DONE    = '{KIND_DONE, 8'h00, 16'h0, 16'h0, 1'b0, 8'h00,
                                           ERR_NONE};

   // Directed requests: data, first, last, typed expectation, expected result
   localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
      '{BYTE_FILL,   1'b1, 1'b1, 1'b1, R_TRUNC},    // file ends inside the start bytes
      '{BYTE_FILL,   1'b1, 1'b0, 1'b0, NO_RES},
      '{8'h00,       1'b0, 1'b0, 1'b1, R_BAD_SOI},  // bad second start byte
      '{BYTE_FILL,   1'b1, 1'b0, 1'b0, NO_RES},
      '{MARKER_SOI,  1'b0, 1'b0, 1'b0, NO_RES},
      '{MARKER_COM,  1'b0, 1'b0, 1'b0, NO_RES},     // comment, three payload bytes
      '{8'h00,       1'b0, 1'b0, 1'b0, NO_RES},
      '{8'h05,       1'b0, 1'b0, 1'b0, NO_RES},
      '{8'h00,       1'b0, 1'b0, 1'b0, NO_RES},     // zero byte is dropped
      '{8'hFF,       1'b0, 1'b0, 1'b1, R_COM_FF},
      '{8'h01,       1'b0, 1'b0, 1'b0, NO_RES},
      '{MARKER_APP1, 1'b0, 1'b0, 1'b0, NO_RES},     // short EXIF, not counted
      '{8'h00,       1'b0, 1'b0, 1'b0, NO_RES},
      '{8'h04,       1'b0, 1'b0, 1'b0, NO_RES},
      '{8'h45,       1'b0, 1'b0, 1'b0, NO_RES},
      '{8'h78,       1'b0, 1'b0, 1'b0, NO_RES},
      '{8'hC1,       1'b0, 1'b0, 1'b0, NO_RES},     // short frame header
      '{8'h00,       1'b0, 1'b0, 1'b0, NO_RES},
      '{8'h05,       1'b0, 1'b0, 1'b0, NO_RES},
      '{8'h08,       1'b0, 1'b0, 1'b0, NO_RES},
      '{8'hFF,       1'b0, 1'b0, 1'b0, NO_RES},
      '{8'hFF,       1'b0, 1'b0, 1'b0, NO_RES},
      '{MARKER_SOS,  1'b0, 1'b0, 1'b0, NO_RES},     // scan header ends the walk
      '{8'h00,       1'b0, 1'b0, 1'b0, NO_RES},
      '{8'h02,       1'b0, 1'b0, 1'b1, R_DONE},
      '{8'h55,       1'b0, 1'b1, 1'b0, NO_RES},     // swallowed after done
      '{BYTE_FILL,   1'b1, 1'b0, 1'b0, NO_RES},
      '{MARKER_SOI,  1'b0, 1'b0, 1'b0, NO_RES},
      '{MARKER_EOI,  1'b0, 1'b0, 1'b1, R_EOI}       // end of image before any scan
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_first_byte = 1'b0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_comment_byte;
   logic [15:0] rsp_frame_height;
   logic [15:0] rsp_frame_width;
   logic        rsp_is_color;
   logic [7:0]  rsp_process_marker;
   logic [2:0]  rsp_error_code;

   jpeg_marker_segment_parser #(.MAX_SEGMENTS(MAX_SEGMENTS)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_first_byte     (req_first_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_comment_byte   (rsp_comment_byte),
      .rsp_frame_height   (rsp_frame_height),
      .rsp_frame_width    (rsp_frame_width),
      .rsp_is_color       (rsp_is_color),
      .rsp_process_marker (rsp_process_marker),
      .rsp_error_code     (rsp_error_code)
   );

   always #5 clock = ~clock;

   parse_result_t pending_results [$];
   file_byte_t    file_q [$];
   int            failures = 0;
   int            sent = 0;
   logic          calm = 1'b0;
   logic          cur_typed = 1'b0;
   parse_result_t cur_want = '0;

   // Shadow parser state
   phase_type   ps_phase;
   logic [2:0]  ps_fill;
   logic [7:0]  ps_marker;
   logic [7:0]  ps_len_hi;
   logic [7:0]  ps_ncomp;
   logic [15:0] ps_left;
   logic [15:0] ps_pos;
   logic [15:0] ps_height;
   logic [15:0] ps_width;
   logic        ps_exif;
   logic [5:0]  ps_sections;
   // Per-request outcome
   logic        ps_emit;
   logic [1:0]  ps_kind;
   logic [7:0]  ps_char;
   logic [2:0]  ps_err;
   logic        ps_done_due;

   function automatic logic frame_marker(input logic [7:0] m);
      return m >= SOF_FIRST && m <= SOF_LAST &&
             m != MARKER_DHT && m != MARKER_JPG && m != MARKER_DAC;
   endfunction

   task automatic clear_parser();
      ps_phase    = PH_SOI0;
      ps_fill     = '0;
      ps_marker   = '0;
      ps_len_hi   = '0;
      ps_left     = '0;
      ps_pos      = '0;
      ps_height   = '0;
      ps_width    = '0;
      ps_ncomp    = '0;
      ps_exif     = 1'b1;
      ps_sections = '0;
   endtask

   task automatic raise_error(input logic [2:0] code);
      ps_emit  = 1'b1;
      ps_kind  = KIND_ERROR;
      ps_err   = code;
      ps_phase = PH_IDLE;
   endtask

   // End of a segment: count it, report frame info, check for completion
   task automatic close_segment();
      logic counted;
      counted  = 1'b1;
      ps_phase = PH_FILL;
      ps_fill  = '0;
      if (ps_marker == MARKER_SOS) begin
         ps_sections = ps_sections + 6'd1;
         ps_done_due = 1'b1;
      end else begin
         if (ps_marker == MARKER_APP0) counted = 1'b0;
         if (ps_marker == MARKER_APP1 && !(ps_exif && ps_pos >= 16'd4)) counted = 1'b0;
         if (counted) ps_sections = ps_sections + 6'd1;
         if (frame_marker(ps_marker)) begin
            ps_emit = 1'b1;
            ps_kind = KIND_FRAME;
         end
         if (ps_sections >= 6'(MAX_SEGMENTS - 1)) ps_done_due = 1'b1;
      end
   endtask

   task automatic take_payload(input logic [7:0] b);
      if (ps_marker == MARKER_COM && b != 8'h00) begin
         ps_emit = 1'b1;
         ps_kind = KIND_COMMENT;
         ps_char = b;
      end
      if (frame_marker(ps_marker)) begin
         case (ps_pos)
            16'd1:   ps_height[15:8] = b;
            16'd2:   ps_height[7:0]  = b;
            16'd3:   ps_width[15:8]  = b;
            16'd4:   ps_width[7:0]   = b;
            16'd5:   ps_ncomp        = b;
            default: ;
         endcase
      end
      if (ps_marker == MARKER_APP1 && ps_pos < 16'd4 &&
          b != 8'(EXIF_TAG >> (24 - 8 * ps_pos[1:0])))
         ps_exif = 1'b0;
      if (ps_pos != 16'hFFFF) ps_pos = ps_pos + 16'd1;
      ps_left = ps_left - 16'd1;
      if (ps_left == 16'd0) close_segment();
   endtask

   // Predict the result, if any, of one accepted request
   task automatic parse_byte(input logic [7:0] b, input logic first, input logic last,
                             output logic emit, output parse_result_t res);
      logic [15:0] seg_len;
      ps_emit     = 1'b0;
      ps_kind     = KIND_COMMENT;
      ps_char     = 8'h00;
      ps_err      = ERR_NONE;
      ps_done_due = 1'b0;
      if (first) clear_parser();
      case (ps_phase)
         PH_SOI0: begin
            if (b != BYTE_FILL) raise_error(ERR_BAD_START);
            else ps_phase = PH_SOI1;
         end
         PH_SOI1: begin
            if (b != MARKER_SOI) raise_error(ERR_BAD_START);
            else begin
               ps_phase = PH_FILL;
               ps_fill  = '0;
            end
         end
         PH_FILL: begin
            if (b == BYTE_FILL) begin
               if (ps_fill >= 3'(MAXFILL)) raise_error(ERR_FILL);
               else ps_fill = ps_fill + 3'd1;
            end else begin
               ps_marker = b;
               ps_fill   = '0;
               if (b == MARKER_EOI) raise_error(ERR_EOI);
               else ps_phase = PH_LENH;
            end
         end
         PH_LENH: begin
            ps_len_hi = b;
            ps_phase  = PH_LENL;
         end
         PH_LENL: begin
            seg_len = {ps_len_hi, b};
            if (seg_len < 16'd2) raise_error(ERR_LENGTH);
            else begin
               ps_left   = seg_len - 16'd2;
               ps_pos    = '0;
               ps_height = '0;
               ps_width  = '0;
               ps_ncomp  = '0;
               ps_exif   = 1'b1;
               ps_phase  = PH_BODY;
               if (ps_left == 16'd0) close_segment();
            end
         end
         PH_BODY: take_payload(b);
         PH_PEND: begin
            ps_emit  = 1'b1;
            ps_kind  = KIND_DONE;
            ps_phase = PH_IDLE;
         end
         default: ;
      endcase

      // Done with a data result waits one request, unless the file ends here
      if (ps_done_due) begin
         if (ps_emit && !last) ps_phase = PH_PEND;
         else begin
            ps_emit  = 1'b1;
            ps_kind  = KIND_DONE;
            ps_char  = 8'h00;
            ps_phase = PH_IDLE;
         end
      end

      // Last byte while still walking: truncated file
      if (last && ps_kind != KIND_DONE && ps_kind != KIND_ERROR && ps_phase != PH_IDLE) begin
         ps_emit  = 1'b1;
         ps_kind  = KIND_ERROR;
         ps_err   = ERR_TRUNCATED;
         ps_phase = PH_IDLE;
      end

      emit               = ps_emit;
      res.kind           = ps_kind;
      res.comment_byte   = (ps_kind == KIND_COMMENT) ? ps_char : 8'h00;
      res.frame_height   = (ps_kind == KIND_FRAME) ? ps_height : 16'h0;
      res.frame_width    = (ps_kind == KIND_FRAME) ? ps_width : 16'h0;
      res.is_color       = (ps_kind == KIND_FRAME) && (ps_ncomp == 8'd3);
      res.process_marker = (ps_kind == KIND_FRAME) ? ps_marker : 8'h00;
      res.error_code     = (ps_kind == KIND_ERROR) ? ps_err : ERR_NONE;
   endtask

   // Check results, then predict for the request taken at this edge
   always @(posedge clock) begin : monitor
      parse_result_t got;
      parse_result_t want;
      parse_result_t predicted;
      logic          emit;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_kind, rsp_comment_byte, rsp_frame_height, rsp_frame_width,
                    rsp_is_color, rsp_process_marker, rsp_error_code};
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result kind=%0d byte=%02h err=%0d",
                        $time, got.kind, got.comment_byte, got.error_code);
               failures++;
            end else begin
               want = pending_results.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected kind=%0d byte=%02h h=%04h w=%04h c=%0d m=%02h e=%0d",
                           $time, want.kind, want.comment_byte, want.frame_height,
                           want.frame_width, want.is_color, want.process_marker,
                           want.error_code);
                  $display("%0t:          actual   kind=%0d byte=%02h h=%04h w=%04h c=%0d m=%02h e=%0d",
                           $time, got.kind, got.comment_byte, got.frame_height,
                           got.frame_width, got.is_color, got.process_marker,
                           got.error_code);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            parse_byte(req_data_byte, req_first_byte, req_last_byte, emit, predicted);
            if (cur_typed) pending_results.push_back(cur_want);
            else if (emit) pending_results.push_back(predicted);
         end
      end
   end

   // Result side stalls at random, except in the calm stretch
   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
   end

   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic send_req(input logic [7:0] d, input logic f, input logic l,
                           input logic typed, input parse_result_t want);
      calm = (sent >= CALM_FIRST) && (sent < CALM_LAST);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= d;
      req_first_byte <= f;
      req_last_byte  <= l;
      cur_typed       = typed;
      cur_want        = want;
      do @(posedge clock); while (req_stall);
      sent++;
      @(negedge clock);
   endtask

   task automatic push_byte(input logic [7:0] d);
      file_q.push_back('{d, file_q.size() == 0, 1'b0});
   endtask

   // Build one random file: mostly well formed, some broken, some noise
   task automatic build_file();
      int         style;
      int         nseg;
      int         nfill;
      int         seg_len;
      int         r;
      int         cut;
      logic       broken;
      logic       big;
      logic       exif_head;
      logic       tri_color;
      logic [7:0] mk;
      logic [7:0] pb;
      file_q.delete();
      style = $urandom_range(0, 99);
      if (style < 10) begin
         repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
         foreach (file_q[i]) begin
            file_q[i].first = (i == 0) || ($urandom_range(0, 7) == 0);
            file_q[i].last  = $urandom_range(0, 5) == 0;
         end
         return;
      end
      broken = style < 30;
      nseg   = (style < 65) ? $urandom_range(20, 28) : $urandom_range(1, 6);
      push_byte(BYTE_FILL);
      push_byte((broken && $urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                                       : MARKER_SOI);
      for (int s = 0; s < nseg; s++) begin
         nfill = (broken && $urandom_range(0, 19) == 0) ? 7 :
                 ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
         repeat (nfill) push_byte(BYTE_FILL);
         r = $urandom_range(0, 99);
         if (r < 22) mk = MARKER_COM;
         else if (r < 45) mk = SOF_FIRST + 8'($urandom_range(0, 15));
         else if (r < 55) mk = MARKER_APP0;
         else if (r < 70) mk = MARKER_APP1;
         else if (broken && r < 74) mk = MARKER_EOI;
         else if (broken && r < 77) mk = MARKER_SOS;
         else if (broken) mk = 8'($urandom_range(0, 254));
         else if (r < 85) mk = MARKER_DQT;
         else mk = 8'($urandom_range(8'hE2, 8'hEF));
         if (s == nseg - 1 && $urandom_range(0, 1) == 1) mk = MARKER_SOS;
         push_byte(mk);
         r   = $urandom_range(0, 11);
         big = 1'b0;
         if (broken && r == 0) seg_len = $urandom_range(0, 1);
         else if (broken && r == 1) begin
            seg_len = $urandom_range(16'h0100, 16'hFFFF);
            big     = 1'b1;
         end else if (frame_marker(mk)) seg_len = 2 + $urandom_range(0, 7);
         else seg_len = 2 + $urandom_range(0, 4);
         push_byte(8'(seg_len >> 8));
         push_byte(8'(seg_len));
         exif_head = $urandom_range(0, 9) < 6;
         tri_color = $urandom_range(0, 1) == 1;
         for (int i = 0; i < seg_len - 2 && i < 12; i++) begin
            pb = 8'($urandom_range(0, 255));
            if (mk == MARKER_COM && $urandom_range(0, 3) == 0) pb = 8'h00;
            if (frame_marker(mk) && i == 5 && tri_color) pb = 8'd3;
            if (mk == MARKER_APP1 && i < 4 && exif_head && $urandom_range(0, 9) != 0)
               pb = 8'(EXIF_TAG >> (24 - 8 * i));
            push_byte(pb);
         end
         if (big) break;
      end
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
      r = $urandom_range(0, 9);
      if (r < 6) file_q[$].last = 1'b1;
      else if (r < 8) begin
         cut = $urandom_range(0, file_q.size() - 1);
         while (file_q.size() > cut + 1) void'(file_q.pop_back());
         file_q[$].last = 1'b1;
      end
   endtask

   // Stimulus and end of run
   initial begin : driver
      int files;
      int drain;
      files = 0;
      clear_parser();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++)
         send_req(DIRECTED[i].data, DIRECTED[i].first, DIRECTED[i].last,
                  DIRECTED[i].typed, DIRECTED[i].want);

      while (sent < ITEM_TARGET + DIR_ROWS) begin
         // Hold off until every expected result is back
         if (files == 2 || $urandom_range(0, 24) == 0) begin
            req_valid <= 1'b0;
            @(negedge clock);
            while (pending_results.size() != 0) @(negedge clock);
         end
         build_file();
         foreach (file_q[i])
            send_req(file_q[i].data, file_q[i].first, file_q[i].last, 1'b0, NO_RES);
         files++;
      end
      req_valid <= 1'b0;

      drain = 0;
      while (pending_results.size() != 0 && drain < 10000) begin
         @(posedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d expected results never arrived, next kind=%0d",
                  $time, pending_results.size(), pending_results[0].kind);
         failures++;
      end
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("%0t: timeout", $time);
      $display("== FAIL ==");
      $finish;
   end

endmodule
